[hw/rtl/hklp_pkg.sv]
// shared types and constants for the string key hash table
// controller states, status codes, command and status bundles
// no dependencies
package hklp_pkg;

  // table size, a power of two so the start slot is the low hash bits
  localparam int SLOTS_DEF     = 256;
  localparam int KEY_BYTES_DEF = 32;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PRB_RD,
    S_PRB_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_CPY_RD,
    S_CPY_WR,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    acc;
    logic    mod_step;
    logic    idx_adv;
    logic    j_clr;
    logic    j_inc;
    logic    copy_wr;
    logic    meta_wr;
    logic    clr_wr;
    logic    cnt_inc;
    logic    out_load;
    logic    key_done;
    status_t res;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic meta_valid;
    logic len_eq;
    logic byte_eq;
    logic j_last;
    logic full;
    logic act;
  } sts_t;

  // one fnv-1a round; the prime is 2^40 + 0x1b3, built from shifts
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

[hw/rtl/hklp_in_if.sv]
// key byte channel: valid/ready plus action, key byte and last flag
// depends on nothing
interface hklp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] key_byte;
  logic       last;
  modport source (output valid, action, key_byte, last, input ready);
  modport sink   (input valid, action, key_byte, last, output ready);
endinterface

[hw/rtl/hklp_out_if.sv]
// result channel: valid/ready plus status and slot
// depends on nothing
interface hklp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] slot;
  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

[hw/rtl/string_key_hash_table_linear_probe.sv]
// string key hash table, fnv-1a 64 hash with linear probing
// non-final key beats fold into the hash; a final beat goes on to take the start slot,
// read and check each probed slot and key byte, copy the key on insert, then emit
// no further beats are taken until the result is loaded into the output register
// after reset a clearing pass empties every slot table entry, no beats taken
// depends on hklp_pkg, hklp_in_if, hklp_out_if, hklp_ram, hklp_ctrl, hklp_dp
module string_key_hash_table_linear_probe #(
  parameter int KEY_BYTES = hklp_pkg::KEY_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  hklp_in_if.sink    in_ch,
  hklp_out_if.source out_ch
);
  hklp_pkg::cmd_t cmd;
  hklp_pkg::sts_t sts;

  // sequencer: owns handshakes and the result valid flag
  hklp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hash, index, rams and the result payload register
  hklp_dp #(.KEY_BYTES(KEY_BYTES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_action   (in_ch.action),
    .in_key_byte (in_ch.key_byte),
    .sts         (sts),
    .out_status  (out_ch.status),
    .out_slot    (out_ch.slot)
  );

  // a result is loaded only into an empty or draining output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result beat overwritten");

  // an insert never lands in a table that must keep one slot empty
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert into full table");

  // the final key beat starts the probe and blocks further beats
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last) |=> !in_ch.ready)
    else $error("beat taken during probe");
endmodule

[hw/rtl/hklp_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module hklp_ram #(
  parameter int W = 8,
  parameter int D = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 2) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic [((D > 2) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/hklp_ctrl.sv]
// sequencer for clear, hash reduction, probe walk, key copy and result
// depends on hklp_pkg
module hklp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  hklp_pkg::sts_t  sts,
  output hklp_pkg::cmd_t  cmd
);
  hklp_pkg::state_t  state_r, state_nxt;
  hklp_pkg::status_t res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hklp_pkg::S_CLEAR;
      res_r       <= hklp_pkg::ST_ABSENT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    cmd.res   = res_r;
    in_ready  = 1'b0;
    unique case (state_r)
      hklp_pkg::S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = hklp_pkg::S_IDLE;
        end
      end
      hklp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last) begin
            state_nxt = hklp_pkg::S_MOD;
          end
        end
      end
      hklp_pkg::S_MOD: begin
        cmd.mod_step = 1'b1;
        state_nxt    = hklp_pkg::S_PRB_RD;
      end
      hklp_pkg::S_PRB_RD: begin
        state_nxt = hklp_pkg::S_PRB_CHK;
      end
      hklp_pkg::S_PRB_CHK: begin
        if (!sts.meta_valid) begin
          if (!sts.act) begin
            res_nxt   = hklp_pkg::ST_ABSENT;
            state_nxt = hklp_pkg::S_EMIT;
          end else if (sts.full) begin
            res_nxt   = hklp_pkg::ST_FULL;
            state_nxt = hklp_pkg::S_EMIT;
          end else begin
            cmd.j_clr = 1'b1;
            state_nxt = hklp_pkg::S_CPY_RD;
          end
        end else if (sts.len_eq) begin
          cmd.j_clr = 1'b1;
          state_nxt = hklp_pkg::S_CMP_RD;
        end else begin
          cmd.idx_adv = 1'b1;
          state_nxt   = hklp_pkg::S_PRB_RD;
        end
      end
      hklp_pkg::S_CMP_RD: begin
        state_nxt = hklp_pkg::S_CMP_CHK;
      end
      hklp_pkg::S_CMP_CHK: begin
        if (!sts.byte_eq) begin
          cmd.idx_adv = 1'b1;
          state_nxt   = hklp_pkg::S_PRB_RD;
        end else if (sts.j_last) begin
          res_nxt   = hklp_pkg::ST_FOUND;
          state_nxt = hklp_pkg::S_EMIT;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = hklp_pkg::S_CMP_RD;
        end
      end
      hklp_pkg::S_CPY_RD: begin
        state_nxt = hklp_pkg::S_CPY_WR;
      end
      hklp_pkg::S_CPY_WR: begin
        cmd.copy_wr = 1'b1;
        if (sts.j_last) begin
          cmd.meta_wr = 1'b1;
          cmd.cnt_inc = 1'b1;
          res_nxt     = hklp_pkg::ST_INSERTED;
          state_nxt   = hklp_pkg::S_EMIT;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = hklp_pkg::S_CPY_RD;
        end
      end
      hklp_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.key_done = 1'b1;
          state_nxt    = hklp_pkg::S_IDLE;
        end
      end
      default: state_nxt = hklp_pkg::S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;
endmodule

[hw/rtl/hklp_dp.sv]
// datapath: fnv-1a hash, start slot from low hash bits, probe index, key and slot rams
// depends on hklp_pkg and hklp_ram
module hklp_dp #(
  parameter int KEY_BYTES = hklp_pkg::KEY_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hklp_pkg::cmd_t cmd,
  input  logic           in_action,
  input  logic [7:0]     in_key_byte,
  output hklp_pkg::sts_t sts,
  output logic [1:0]     out_status,
  output logic [7:0]     out_slot
);
  localparam int SLOTS = hklp_pkg::SLOTS_DEF;
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(KEY_BYTES + 1);
  localparam int JW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PD = 1 << JW;
  localparam int KD = SLOTS << JW;

  logic [63:0]    hash_r;
  logic [LW-1:0]  plen_r;
  logic           act_r;
  logic [SW-1:0]  idx_r;
  logic [JW-1:0]  j_r;
  logic [SW-1:0]  clr_r;
  logic [CW-1:0]  cnt_r;
  logic [1:0]     status_r;
  logic [7:0]     slot_r;

  logic           room;
  logic [7:0]     pend_rd;
  logic [7:0]     key_rd;
  logic [LW:0]    meta_rd;

  assign room = plen_r < LW'(KEY_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= hklp_pkg::FNV_BASIS;
      plen_r <= '0;
      clr_r  <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.key_done) begin
        hash_r <= hklp_pkg::FNV_BASIS;
        plen_r <= '0;
      end else if (cmd.acc && room) begin
        hash_r <= hklp_pkg::fnv_step(hash_r, in_key_byte);
        plen_r <= plen_r + LW'(1);
      end
      if (cmd.clr_wr) begin
        clr_r <= clr_r + SW'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      act_r <= in_action;
      idx_r <= '0;
    end else if (cmd.mod_step) begin
      // slot count is a power of two: hash mod slots is the low bits
      idx_r <= hash_r[SW-1:0];
    end else if (cmd.idx_adv) begin
      idx_r <= (idx_r == SW'(SLOTS - 1)) ? '0 : idx_r + SW'(1);
    end
    if (cmd.j_clr) begin
      j_r <= '0;
    end else if (cmd.j_inc) begin
      j_r <= j_r + JW'(1);
    end
    if (cmd.out_load) begin
      status_r <= cmd.res;
      slot_r   <= (cmd.res == hklp_pkg::ST_FOUND || cmd.res == hklp_pkg::ST_INSERTED)
                  ? 8'(idx_r) : 8'd0;
    end
  end

  hklp_ram #(.W(8), .D(PD)) u_pend (
    .clk   (clk),
    .we    (cmd.acc && room),
    .waddr (plen_r[JW-1:0]),
    .wdata (in_key_byte),
    .raddr (j_r),
    .rdata (pend_rd)
  );

  hklp_ram #(.W(8), .D(KD)) u_keys (
    .clk   (clk),
    .we    (cmd.copy_wr),
    .waddr ({idx_r, j_r}),
    .wdata (pend_rd),
    .raddr ({idx_r, j_r}),
    .rdata (key_rd)
  );

  hklp_ram #(.W(LW + 1), .D(SLOTS)) u_meta (
    .clk   (clk),
    .we    (cmd.clr_wr || cmd.meta_wr),
    .waddr (cmd.clr_wr ? clr_r : idx_r),
    .wdata (cmd.clr_wr ? '0 : {1'b1, plen_r}),
    .raddr (idx_r),
    .rdata (meta_rd)
  );

  always_comb begin
    sts            = '0;
    sts.clr_done   = (clr_r == SW'(SLOTS - 1));
    sts.meta_valid = meta_rd[LW];
    sts.len_eq     = (meta_rd[LW-1:0] == plen_r);
    sts.byte_eq    = (key_rd == pend_rd);
    sts.j_last     = ((LW'(j_r) + LW'(1)) == plen_r);
    sts.full       = ((CW+1)'(cnt_r) + (CW+1)'(1)) >= (CW+1)'(SLOTS);
    sts.act        = act_r;
  end

  assign out_status = status_r;
  assign out_slot   = slot_r;
endmodule

[tb/sv/tb_string_key_hash_table_linear_probe.sv]
`timescale 1ns / 100ps
// testbench for the string key hash table: directed table, then random key streams
// predicts status and slot with its own fnv-1a table model; uses hklp_pkg and the
// hklp_in_if / hklp_out_if interfaces
module tb_string_key_hash_table_linear_probe;

  localparam int NSLOT = 256;
  localparam int KEYB  = 32;
  localparam logic [63:0] PRIME = 64'h100000001b3;
  localparam int RAND_KEYS = 120;
  localparam int WD_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hklp_in_if  in_ch ();
  hklp_out_if out_ch ();

  string_key_hash_table_linear_probe i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state: the table contents as the block should hold them
  logic [63:0] key_hash;
  logic [7:0]  key_buf [KEYB];
  int          key_len;
  logic        tbl_used [NSLOT];
  logic [7:0]  tbl_key [NSLOT][KEYB];
  int          tbl_len [NSLOT];
  int          tbl_count;

  typedef struct packed {
    hklp_pkg::status_t status;
    logic [7:0]        slot;
  } lookup_res_t;

  lookup_res_t pending_results[$];
  int errors = 0;
  int mismatches = 0;
  bit quiet_phase = 0;
  bit hold_long = 0;
  bit stim_done = 0;

  // stored keys, reused by the random part so lookups and repeat inserts hit
  logic [7:0] known_keys [$][$];

  // fold one beat into the model; returns 1 with a result on the final beat
  function automatic bit table_step(input logic act, input logic [7:0] b,
                                    input logic fin, output lookup_res_t r);
    int idx;
    int n;
    bit hit;
    bit same;
    hit = 0;
    if (key_len < KEYB) begin
      key_buf[key_len] = b;
      key_len++;
      key_hash = (key_hash ^ {56'd0, b}) * PRIME;
    end
    if (!fin) return 0;
    idx = int'(key_hash % NSLOT);
    for (n = 0; n < NSLOT; n++) begin
      if (!tbl_used[idx]) break;
      same = (tbl_len[idx] == key_len);
      for (int k = 0; k < key_len && same; k++)
        if (tbl_key[idx][k] != key_buf[k]) same = 0;
      if (same) begin
        hit = 1;
        break;
      end
      idx = (idx + 1) % NSLOT;
    end
    r.status = hklp_pkg::ST_ABSENT;
    r.slot = '0;
    if (hit) begin
      r.status = hklp_pkg::ST_FOUND;
      r.slot = idx[7:0];
    end else if (act) begin
      if (tbl_count + 1 >= NSLOT || n >= NSLOT) begin
        r.status = hklp_pkg::ST_FULL;
      end else begin
        tbl_used[idx] = 1'b1;
        for (int k = 0; k < key_len; k++) tbl_key[idx][k] = key_buf[k];
        tbl_len[idx] = key_len;
        tbl_count++;
        r.status = hklp_pkg::ST_INSERTED;
        r.slot = idx[7:0];
      end
    end
    key_hash = hklp_pkg::FNV_BASIS;
    key_len = 0;
    return 1;
  endfunction

  // drive one beat, wait for the handshake, then predict
  task automatic send_beat(input logic act, input logic [7:0] b, input logic fin);
    lookup_res_t r;
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.key_byte <= b;
    in_ch.last <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (table_step(act, b, fin, r)) pending_results.push_back(r);
  endtask

  // send a whole key; rec keeps it for later reuse
  task automatic send_key(input logic act, input logic [7:0] k[$], input bit rec);
    for (int i = 0; i < k.size(); i++)
      send_beat(i == k.size() - 1 ? act : logic'($urandom_range(0, 1)), k[i],
                i == k.size() - 1);
    if (rec) known_keys.push_back(k);
  endtask

  function automatic void rand_key(output logic [7:0] k[$], input int len);
    k = {};
    for (int i = 0; i < len; i++) k.push_back(8'($urandom_range(1, 255)));
  endfunction

  // directed rows: expected status typed in for the fresh-table cases, else predicted
  typedef struct {
    logic act;
    int   len;
    logic [7:0] fill;
    bit   chk;
    hklp_pkg::status_t want;
  } row_t;

  row_t rows [12] = '{
    '{1'b0, 1,  8'h01, 1, hklp_pkg::ST_ABSENT},    // lookup on empty table
    '{1'b1, 1,  8'h01, 1, hklp_pkg::ST_INSERTED},  // smallest key, min byte
    '{1'b1, 1,  8'h01, 1, hklp_pkg::ST_FOUND},     // insert of present key
    '{1'b0, 1,  8'h01, 1, hklp_pkg::ST_FOUND},
    '{1'b1, 1,  8'hff, 1, hklp_pkg::ST_INSERTED},  // max byte
    '{1'b1, 32, 8'haa, 1, hklp_pkg::ST_INSERTED},  // full-length key
    '{1'b0, 40, 8'haa, 1, hklp_pkg::ST_FOUND},     // long key aliases its first 32 bytes
    '{1'b1, 45, 8'haa, 1, hklp_pkg::ST_FOUND},
    '{1'b1, 31, 8'haa, 0, hklp_pkg::ST_FOUND},     // shorter prefix, predicted
    '{1'b0, 2,  8'h55, 1, hklp_pkg::ST_ABSENT},
    '{1'b1, 2,  8'h55, 0, hklp_pkg::ST_FOUND},
    '{1'b0, 2,  8'h55, 1, hklp_pkg::ST_FOUND}
  };

  // stimulus
  initial begin
    logic [7:0] k[$];
    int len;
    int pick;
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.key_byte = 8'h01;
    in_ch.last = 1'b0;
    key_hash = hklp_pkg::FNV_BASIS;
    key_len = 0;
    tbl_count = 0;
    for (int i = 0; i < NSLOT; i++) tbl_used[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      k = {};
      for (int j = 0; j < rows[i].len; j++) k.push_back(rows[i].fill);
      send_key(rows[i].act, k, 0);
      // typed-in expectation must agree with the model; both checked against the dut
      if (rows[i].chk && pending_results[$].status != rows[i].want) begin
        errors++;
        if (mismatches++ < 10)
          $display("directed row %0d: table expects %0d, model %0d", i, rows[i].want,
                   pending_results[$].status);
      end
    end
    // single-beat keys with every bit of the byte toggled
    for (int b = 0; b < 8; b++) begin
      k = {8'(1 << b)};
      send_key(1'b1, k, 1);
    end

    // long receiver hold while keys keep coming
    hold_long = 1;
    for (int i = 0; i < 6; i++) begin
      rand_key(k, $urandom_range(1, 4));
      send_key(1'b1, k, 1);
    end
    hold_long = 0;

    // random part: mostly short keys, reuse of stored ones, some long ones
    for (int i = 0; i < RAND_KEYS; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3 && known_keys.size() > 0) begin
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
        send_key(logic'($urandom_range(0, 1)), k, 0);
      end else begin
        len = (pick == 9) ? $urandom_range(30, 40) : $urandom_range(1, 6);
        rand_key(k, len);
        send_key(logic'(pick < 8), k, 1);
      end
    end
    // fill the table up to the full point, then more inserts get refused
    while (tbl_count < NSLOT - 1) begin
      rand_key(k, 2);
      send_key(1'b1, k, 1);
    end
    quiet_phase = 1;
    for (int i = 0; i < 10; i++) begin
      rand_key(k, 3);
      send_key(1'b1, k, 0);
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      send_key(1'b0, k, 0);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_long = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    lookup_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat status %0d slot %0d",
                                        out_ch.status, out_ch.slot);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.status != e.status || out_ch.slot != e.slot) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     e.status, e.slot, out_ch.status, out_ch.slot);
        end
      end
    end
  end

  // watchdog on cycles without any beat, and the end of the run
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= WD_LIMIT) begin
        $display("string_key_hash_table_linear_probe verification failed");
        $finish;
      end
      if (stim_done && pending_results.size() == 0) begin
        repeat (300) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
          $display("string_key_hash_table_linear_probe verification clean");
        else
          $display("string_key_hash_table_linear_probe verification failed");
        $finish;
      end
    end
  end

endmodule
